/* hw/rtl/tods_pkg.sv */
package tods_pkg;

	typedef enum logic [1:0] {
		FIELD_HOUR,
		FIELD_MIN,
		FIELD_SEC,
		FIELD_NONE
	} field_t;

	typedef enum logic [1:0] {
		REL_NONE,
		REL_PLUS,
		REL_MINUS
	} rel_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
		logic [4:0] now_hour;
		logic [5:0] now_minute;
		logic [5:0] now_second;
	} char_item_t;

	typedef struct packed {
		logic [7:0] hour_out;
		logic [7:0] minute_out;
		logic [7:0] second_out;
		logic       parse_error;
	} result_item_t;

	typedef struct packed {
		field_t     field_select;
		logic [7:0] value_accum;
		logic       value_empty;
		rel_t       relative_mode;
		logic [5:0] offset_accum;
		logic [7:0] hour_reg;
		logic [7:0] minute_reg;
		logic [7:0] second_reg;
		logic       error_seen;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		field_select:  FIELD_HOUR,
		value_accum:   8'd0,
		value_empty:   1'b1,
		relative_mode: REL_NONE,
		offset_accum:  6'd0,
		hour_reg:      8'd0,
		minute_reg:    8'd0,
		second_reg:    8'd0,
		error_seen:    1'b0
	};

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	localparam logic [6:0]  HOUR_MOD   = 7'd24;
	localparam logic [6:0]  MIN_MOD    = 7'd60;
	localparam logic [11:0] VALUE_MAX  = 12'd255;
	localparam logic [9:0]  OFFSET_MAX = 10'd63;

endpackage

/* hw/rtl/tods_step.sv */
module tods_step import tods_pkg::*; (
	input  parse_state_t cur,
	input  char_item_t   item,
	output parse_state_t nxt,
	output result_item_t result
);

	// Closes the field in progress and moves on to the next one.
	function automatic parse_state_t commit(parse_state_t s, char_item_t it);
		parse_state_t r;
		logic [6:0]   now;
		logic [6:0]   modv;
		logic [6:0]   n;
		logic [6:0]   d;
		logic [6:0]   sum;
		logic [7:0]   v;
		r = s;
		case (s.field_select)
			FIELD_HOUR: now = {2'b00, it.now_hour};
			FIELD_MIN:  now = {1'b0, it.now_minute};
			FIELD_SEC:  now = {1'b0, it.now_second};
			default:    now = 7'd0;
		endcase
		modv = (s.field_select == FIELD_HOUR) ? HOUR_MOD : MIN_MOD;
		n = now;
		if (n >= modv) n = n - modv;
		d = {1'b0, s.offset_accum};
		if (d >= modv) d = d - modv;
		if (d >= modv) d = d - modv;
		if (s.relative_mode == REL_PLUS) sum = n + d;
		else sum = n + modv - d;
		if (sum >= modv) sum = sum - modv;
		if (s.relative_mode != REL_NONE) v = {1'b0, sum};
		else if (s.value_empty) v = {1'b0, now};
		else v = s.value_accum;
		case (s.field_select)
			FIELD_HOUR: begin
				r.hour_reg = v;
				r.field_select = FIELD_MIN;
			end
			FIELD_MIN: begin
				r.minute_reg = v;
				r.field_select = FIELD_SEC;
			end
			FIELD_SEC: begin
				r.second_reg = v;
				r.field_select = FIELD_NONE;
			end
			default: r.field_select = FIELD_NONE;
		endcase
		r.value_accum = 8'd0;
		r.value_empty = 1'b1;
		r.relative_mode = REL_NONE;
		r.offset_accum = 6'd0;
		return r;
	endfunction

	parse_state_t s1;
	parse_state_t s2;
	logic [3:0]   digit;
	logic [11:0]  value_calc;
	logic [9:0]   offset_calc;

	assign digit = 4'(item.char_code - CHAR_ZERO);
	assign value_calc = 12'(cur.value_accum) * 12'd10 + 12'(digit);
	assign offset_calc = 10'(cur.offset_accum) * 10'd10 + 10'(digit);

	always_comb begin
		s1 = cur;
		if (item.char_code >= CHAR_ZERO && item.char_code <= CHAR_NINE) begin
			if (cur.relative_mode != REL_NONE) begin
				s1.offset_accum = (offset_calc > OFFSET_MAX) ? 6'(OFFSET_MAX)
					: offset_calc[5:0];
			end else begin
				s1.value_accum = (value_calc > VALUE_MAX) ? 8'(VALUE_MAX) : value_calc[7:0];
				s1.value_empty = 1'b0;
			end
		end else if (item.char_code == CHAR_COLON || item.char_code == CHAR_SLASH) begin
			s1 = commit(cur, item);
		end else if (item.char_code == CHAR_PLUS || item.char_code == CHAR_MINUS) begin
			if (cur.relative_mode != REL_NONE) begin
				s1.error_seen = 1'b1;
			end else begin
				s1.relative_mode = (item.char_code == CHAR_PLUS) ? REL_PLUS : REL_MINUS;
				s1.offset_accum = 6'd0;
				s1.value_accum = 8'd0;
				s1.value_empty = 1'b1;
			end
		end else begin
			s1.error_seen = 1'b1;
		end

		// On the last character the open field is closed and unfilled ones read as zero.
		s2 = commit(s1, item);
		case (s1.field_select)
			FIELD_HOUR: begin
				s2.minute_reg = 8'd0;
				s2.second_reg = 8'd0;
			end
			FIELD_MIN: s2.second_reg = 8'd0;
			default: ;
		endcase

		if (s2.error_seen) begin
			result = '{hour_out: 8'd0, minute_out: 8'd0, second_out: 8'd0, parse_error: 1'b1};
		end else begin
			result = '{hour_out: s2.hour_reg, minute_out: s2.minute_reg,
				second_out: s2.second_reg, parse_error: 1'b0};
		end

		nxt = item.last_char ? STATE_RESET : s1;
	end

endmodule

/* hw/rtl/time_of_day_spec_parser.sv */
// Channel  | Direction | Payload        | Handshake
// char     | in        | char_item_t    | char_valid / char_stall
// result   | out       | result_item_t  | result_valid / result_stall
//
// One character is taken per cycle unless a stalled result holds back a last character; a
// result is loaded into the result register when its last character leaves the input register.
// The input register feeds the parse logic, which updates the field state and, on the
// last character, loads the result register.
// Reset returns the parser to the start of a specification with no result pending.
// A stalled result holds back only a last character; other characters keep flowing.
module time_of_day_spec_parser import tods_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         char_valid,
	output logic         char_stall,
	input  char_item_t   char_data,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_data
);

	logic         valid_s1;
	char_item_t   item_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_item_t step_result;
	logic         result_valid_q;
	result_item_t result_q;
	logic         step_en;

	tods_step u_step (
		.cur    (state_q),
		.item   (item_s1),
		.nxt    (state_nxt),
		.result (step_result)
	);

	assign step_en = valid_s1 && (!item_s1.last_char || !result_valid_q || !result_stall);
	assign char_stall = valid_s1 && !step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			item_s1 <= char_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (step_en) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step_en && item_s1.last_char) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && item_s1.last_char) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data = result_q;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import tods_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 12;
	localparam int MAX_REPORTS  = 10;
	localparam int PHASE_CHARS  = 325;
	localparam int PHASE_COUNT  = 4;

	localparam int SEND_IDLE_PCT [PHASE_COUNT] = '{0, 70, 0, 16};
	localparam int RECV_STALL_PCT [PHASE_COUNT] = '{0, 0, 70, 16};

	typedef struct packed {
		logic [7:0]   code;
		logic         last;
		logic [4:0]   nh;
		logic [5:0]   nm;
		logic [5:0]   ns;
		logic         typed;
		result_item_t want;
	} spec_row_t;

	localparam result_item_t NO_WANT    = '0;
	localparam result_item_t ERROR_WANT = {8'd0, 8'd0, 8'd0, 1'b1};

	localparam int DIRECTED_ROWS = 25;
	localparam spec_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{CHAR_ZERO + 8'd7, 1'b1, 5'd0, 6'd0, 6'd0, 1'b1, {8'd7, 8'd0, 8'd0, 1'b0}},
		'{CHAR_NINE, 1'b0, 5'd0, 6'd0, 6'd0, 1'b0, NO_WANT},
		'{CHAR_NINE, 1'b0, 5'd0, 6'd0, 6'd0, 1'b0, NO_WANT},
		'{CHAR_NINE, 1'b1, 5'd0, 6'd0, 6'd0, 1'b1, {8'd255, 8'd0, 8'd0, 1'b0}},
		'{8'hFF, 1'b1, 5'd0, 6'd0, 6'd0, 1'b1, ERROR_WANT},
		'{CHAR_ZERO + 8'd1, 1'b0, 5'd5, 6'd6, 6'd7, 1'b0, NO_WANT},
		'{CHAR_COLON, 1'b0, 5'd5, 6'd6, 6'd7, 1'b0, NO_WANT},
		'{CHAR_ZERO + 8'd2, 1'b0, 5'd5, 6'd6, 6'd7, 1'b0, NO_WANT},
		'{CHAR_SLASH, 1'b0, 5'd5, 6'd6, 6'd7, 1'b0, NO_WANT},
		'{CHAR_ZERO + 8'd3, 1'b0, 5'd5, 6'd6, 6'd7, 1'b0, NO_WANT},
		'{CHAR_COLON, 1'b0, 5'd5, 6'd6, 6'd7, 1'b0, NO_WANT},
		'{CHAR_ZERO + 8'd4, 1'b1, 5'd5, 6'd6, 6'd7, 1'b1, {8'd1, 8'd2, 8'd3, 1'b0}},
		'{CHAR_PLUS, 1'b0, 5'd0, 6'd0, 6'd0, 1'b0, NO_WANT},
		'{CHAR_MINUS, 1'b1, 5'd0, 6'd0, 6'd0, 1'b1, ERROR_WANT},
		'{CHAR_NINE, 1'b0, 5'd31, 6'd63, 6'd0, 1'b0, NO_WANT},
		'{CHAR_PLUS, 1'b0, 5'd31, 6'd63, 6'd0, 1'b0, NO_WANT},
		'{CHAR_NINE, 1'b0, 5'd31, 6'd63, 6'd0, 1'b0, NO_WANT},
		'{CHAR_SLASH, 1'b0, 5'd31, 6'd63, 6'd0, 1'b0, NO_WANT},
		'{CHAR_MINUS, 1'b0, 5'd31, 6'd63, 6'd0, 1'b0, NO_WANT},
		'{CHAR_ZERO + 8'd7, 1'b1, 5'd31, 6'd63, 6'd0, 1'b0, NO_WANT},
		'{CHAR_COLON, 1'b1, 5'd31, 6'd63, 6'd63, 1'b0, NO_WANT},
		'{CHAR_PLUS, 1'b0, 5'd20, 6'd40, 6'd50, 1'b0, NO_WANT},
		'{CHAR_NINE, 1'b0, 5'd20, 6'd40, 6'd50, 1'b0, NO_WANT},
		'{CHAR_NINE, 1'b1, 5'd20, 6'd40, 6'd50, 1'b0, NO_WANT},
		'{8'h00, 1'b1, 5'd0, 6'd0, 6'd0, 1'b1, ERROR_WANT}
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         char_valid = 1'b0;
	logic         char_stall;
	char_item_t   char_data = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_data;

	// Shadow of the offered character: a typed expectation travels with it.
	logic         char_typed = 1'b0;
	result_item_t char_want = '0;

	logic         hold_request = 1'b0;
	logic         hold_active = 1'b0;
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	int unsigned  cycle_count = 0;

	result_item_t expected_results[$];
	int unsigned  mismatches = 0;
	int unsigned  chars_taken = 0;
	int unsigned  results_checked = 0;

	// Parser state as predicted.
	field_t       spec_field;
	logic [7:0]   spec_value;
	logic         spec_blank;
	rel_t         spec_rel;
	logic [5:0]   spec_offset;
	logic [7:0]   spec_hour;
	logic [7:0]   spec_minute;
	logic [7:0]   spec_second;
	logic         spec_error;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	time_of_day_spec_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_data    (char_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	task automatic clear_parse();
		spec_field  = FIELD_HOUR;
		spec_value  = 8'd0;
		spec_blank  = 1'b1;
		spec_rel    = REL_NONE;
		spec_offset = 6'd0;
		spec_hour   = 8'd0;
		spec_minute = 8'd0;
		spec_second = 8'd0;
		spec_error  = 1'b0;
	endtask

	function automatic int unsigned current_for_field(input char_item_t it);
		case (spec_field)
			FIELD_HOUR: return it.now_hour;
			FIELD_MIN:  return it.now_minute;
			FIELD_SEC:  return it.now_second;
			default:    return 0;
		endcase
	endfunction

	task automatic store_value(input logic [7:0] v);
		case (spec_field)
			FIELD_HOUR: begin
				spec_hour = v;
				spec_field = FIELD_MIN;
			end
			FIELD_MIN: begin
				spec_minute = v;
				spec_field = FIELD_SEC;
			end
			FIELD_SEC: begin
				spec_second = v;
				spec_field = FIELD_NONE;
			end
			default: ;
		endcase
	endtask

	task automatic close_field(input char_item_t it);
		int unsigned now_v;
		int unsigned m;
		int unsigned v;
		now_v = current_for_field(it);
		if (spec_rel != REL_NONE) begin
			m = (spec_field == FIELD_HOUR) ? HOUR_MOD : MIN_MOD;
			// The minus case adds the modulus first so that it never goes negative.
			if (spec_rel == REL_PLUS)
				v = (now_v % m + spec_offset % m) % m;
			else
				v = (now_v % m + m - spec_offset % m) % m;
		end else if (spec_blank) begin
			v = now_v;
		end else begin
			v = spec_value;
		end
		store_value(v[7:0]);
		spec_value  = 8'd0;
		spec_blank  = 1'b1;
		spec_rel    = REL_NONE;
		spec_offset = 6'd0;
	endtask

	task automatic parse_char(input char_item_t it, output bit emitted, output result_item_t res);
		int unsigned t;
		emitted = 1'b0;
		res = '0;
		if (it.char_code >= CHAR_ZERO && it.char_code <= CHAR_NINE) begin
			if (spec_rel != REL_NONE) begin
				t = spec_offset * 10 + (it.char_code - CHAR_ZERO);
				spec_offset = (t > OFFSET_MAX) ? OFFSET_MAX[5:0] : t[5:0];
			end else begin
				t = spec_value * 10 + (it.char_code - CHAR_ZERO);
				spec_value = (t > VALUE_MAX) ? VALUE_MAX[7:0] : t[7:0];
				spec_blank = 1'b0;
			end
		end else if (it.char_code == CHAR_COLON || it.char_code == CHAR_SLASH) begin
			close_field(it);
		end else if (it.char_code == CHAR_PLUS || it.char_code == CHAR_MINUS) begin
			if (spec_rel != REL_NONE) begin
				spec_error = 1'b1;
			end else begin
				spec_rel    = (it.char_code == CHAR_PLUS) ? REL_PLUS : REL_MINUS;
				spec_offset = 6'd0;
				spec_value  = 8'd0;
				spec_blank  = 1'b1;
			end
		end else begin
			spec_error = 1'b1;
		end

		if (it.last_char) begin
			close_field(it);
			while (spec_field != FIELD_NONE)
				store_value(8'd0);
			emitted = 1'b1;
			if (spec_error) begin
				res.parse_error = 1'b1;
			end else begin
				res.hour_out   = spec_hour;
				res.minute_out = spec_minute;
				res.second_out = spec_second;
			end
			clear_parse();
		end
	endtask

	task automatic note_mismatch(input string what, input result_item_t want,
			input result_item_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s at cycle %0d: expected %0d:%0d:%0d err %0b, got %0d:%0d:%0d err %0b",
				what, cycle_count, want.hour_out, want.minute_out, want.second_out,
				want.parse_error, got.hour_out, got.minute_out, got.second_out,
				got.parse_error);
	endtask

	// Input and output transfers are handled in one process, input first, so that the
	// order of prediction and checking is fixed.
	always @(posedge clk) begin
		bit           emitted;
		result_item_t predicted;
		result_item_t want;
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				parse_char(char_data, emitted, predicted);
				chars_taken++;
				if (emitted)
					expected_results.push_back(char_typed ? char_want : predicted);
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					note_mismatch("Unexpected result", NO_WANT, result_data);
				end else begin
					want = expected_results.pop_front();
					if (want.hour_out !== result_data.hour_out
							|| want.minute_out !== result_data.minute_out
							|| want.second_out !== result_data.second_out
							|| want.parse_error !== result_data.parse_error)
						note_mismatch("Result mismatch", want, result_data);
					results_checked++;
				end
			end
		end
		result_stall <= hold_active || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out with %0d results outstanding.", expected_results.size());
			$display("time_of_day_spec_parser regression: fail");
			$finish;
		end
	end

	// One long hold-off of the result channel while characters keep arriving.
	initial begin
		@(posedge clk);
		while (!hold_request)
			@(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	task automatic offer_char(input char_item_t it, input logic typed, input result_item_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= it;
		char_typed <= typed;
		char_want  <= want;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		char_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic pick_now(output logic [4:0] nh, output logic [5:0] nm, output logic [5:0] ns);
		// Now and then the current time is out of range, to exercise the modulo.
		if ($urandom_range(7) == 0) begin
			nh = 5'($urandom);
			nm = 6'($urandom);
			ns = 6'($urandom);
		end else begin
			nh = 5'($urandom_range(23));
			nm = 6'($urandom_range(59));
			ns = 6'($urandom_range(59));
		end
	endtask

	task automatic add_digits(ref logic [7:0] codes[$], input int n);
		for (int i = 0; i < n; i++)
			codes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic build_spec(ref char_item_t spec[$]);
		logic [7:0]  codes[$];
		int unsigned nfields;
		int unsigned kind;
		logic [4:0]  nh;
		logic [5:0]  nm;
		logic [5:0]  ns;
		char_item_t  it;
		spec.delete();
		nfields = ($urandom_range(5) == 0) ? $urandom_range(4, 5) : $urandom_range(1, 3);
		for (int f = 0; f < nfields; f++) begin
			if (f != 0)
				codes.push_back($urandom_range(1) ? CHAR_COLON : CHAR_SLASH);
			kind = $urandom_range(9);
			if (kind >= 2 && kind < 6) begin
				add_digits(codes, ($urandom_range(7) == 0) ? 4 : $urandom_range(1, 3));
			end else if (kind >= 6) begin
				// Digits before the sign are discarded by the parser.
				if (kind == 9)
					add_digits(codes, $urandom_range(1, 2));
				codes.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
				add_digits(codes, $urandom_range(3));
			end
		end
		if ($urandom_range(9) == 0)
			codes.insert($urandom_range(codes.size()), $urandom_range(1)
				? 8'($urandom_range(255)) : ($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS));
		if (codes.size() == 0 || $urandom_range(7) == 0)
			codes.push_back($urandom_range(1) ? CHAR_COLON : CHAR_SLASH);

		pick_now(nh, nm, ns);
		foreach (codes[i]) begin
			if ($urandom_range(5) == 0)
				pick_now(nh, nm, ns);
			it.char_code  = codes[i];
			it.last_char  = (i == codes.size() - 1);
			it.now_hour   = nh;
			it.now_minute = nm;
			it.now_second = ns;
			spec.push_back(it);
		end
	endtask

	initial begin
		char_item_t  spec[$];
		char_item_t  it;
		int unsigned sent;
		clear_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			it.char_code  = DIRECTED[i].code;
			it.last_char  = DIRECTED[i].last;
			it.now_hour   = DIRECTED[i].nh;
			it.now_minute = DIRECTED[i].nm;
			it.now_second = DIRECTED[i].ns;
			offer_char(it, DIRECTED[i].typed, DIRECTED[i].want);
		end
		wait_drained();

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			send_idle_pct = SEND_IDLE_PCT[ph];
			stall_pct <= RECV_STALL_PCT[ph];
			if (ph == 0)
				hold_request <= 1'b1;
			sent = 0;
			while (sent < PHASE_CHARS) begin
				build_spec(spec);
				foreach (spec[i])
					offer_char(spec[i], 1'b0, NO_WANT);
				sent += spec.size();
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d characters and checked %0d results across four handshake phases,",
			chars_taken, results_checked);
		$display("with one long result hold-off; %0d mismatches.", mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("time_of_day_spec_parser regression: pass");
		else
			$display("time_of_day_spec_parser regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/tods_pkg.sv
hw/rtl/tods_step.sv
hw/rtl/time_of_day_spec_parser.sv
dv/testbench.sv
